// ===== sv/gtp_pkg.sv =====
// ----------------------------------------------------------------------------
// gtp_pkg: shared types and constants for the go-to-pose controller
// Field widths, CORDIC and root-extraction datapath widths, outcome and
// register codes, and the arctangent table used by every chain cell.
// ----------------------------------------------------------------------------
`default_nettype none

package gtp_pkg;

    // Field widths
    localparam int POS_W  = 16;               // positions, 1/1024 m
    localparam int HDG_W  = 15;               // heading, 1/4096 rad
    localparam int GAIN_W = 12;
    localparam int DIST_W = 16;               // arrive distance
    localparam int LIM_W  = 15;               // heading limit
    localparam int FWD_W  = 15;
    localparam int TURN_W = 16;
    localparam int OUT_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int D_W    = POS_W + 1;        // offset
    localparam int SQ_W   = 32;               // one square, below 2^32
    localparam int DSQ_W  = SQ_W + 1;         // sum of squares
    localparam int RAD_W  = 34;               // radicand, even width
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int CORDIC_SHIFT = 16;
    localparam int XY_W   = 36;
    localparam int Z_W    = 25;               // angle accumulator, 2^-20 rad
    localparam int BEAR_W = Z_W - 8;          // bearing, 1/4096 rad
    localparam int ERR_W  = BEAR_W + 1;

    localparam int SQRT_STEPS      = ROOT_W;
    localparam int MAX_ANGLE_STEPS = 24;
    localparam int ATAN_IDX_W      = 5;

    localparam int FULL_SCALE = 16384;
    localparam logic signed [Z_W-1:0] PI_Q20 = 25'sd3294199;

    // Outcome codes
    localparam logic [OUT_W-1:0] OUT_CONTINUE = 2'd0;
    localparam logic [OUT_W-1:0] OUT_ARRIVED  = 2'd1;
    localparam logic [OUT_W-1:0] OUT_TURN     = 2'd2;
    localparam logic [OUT_W-1:0] OUT_RSVD     = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIST_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HDG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HDG_LIMIT  = 2'd3;

    // State handed from cell to cell
    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
        logic [RAD_W-1:0]        rad;
        logic [REM_W-1:0]        rem;
        logic [ROOT_W-1:0]       root;
        logic signed [HDG_W-1:0] hd;
        logic                    zero;
        logic                    near;
    } t_cell;

    // atan(2^-i) in 2^-20 rad
    function automatic logic signed [Z_W-1:0] atan_q20(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:    v = 25'sd823550;
            5'd1:    v = 25'sd486170;
            5'd2:    v = 25'sd256879;
            5'd3:    v = 25'sd130396;
            5'd4:    v = 25'sd65451;
            5'd5:    v = 25'sd32757;
            5'd6:    v = 25'sd16383;
            5'd7:    v = 25'sd8192;
            5'd8:    v = 25'sd4096;
            5'd9:    v = 25'sd2048;
            5'd10:   v = 25'sd1024;
            5'd11:   v = 25'sd512;
            5'd12:   v = 25'sd256;
            5'd13:   v = 25'sd128;
            5'd14:   v = 25'sd64;
            5'd15:   v = 25'sd32;
            5'd16:   v = 25'sd16;
            5'd17:   v = 25'sd8;
            5'd18:   v = 25'sd4;
            5'd19:   v = 25'sd2;
            5'd20:   v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/gtp_front.sv =====
// ----------------------------------------------------------------------------
// gtp_front: offset, squares and chain entry
// Forms the pose offset, squares it, sums the squares for the root chain and
// tests arrival distance, and pre-rotates the offset for the CORDIC chain.
// ----------------------------------------------------------------------------
`default_nettype none

module gtp_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic signed [gtp_pkg::POS_W-1:0]  i_target_x,
    input  logic signed [gtp_pkg::POS_W-1:0]  i_target_y,
    input  logic signed [gtp_pkg::POS_W-1:0]  i_current_x,
    input  logic signed [gtp_pkg::POS_W-1:0]  i_current_y,
    input  logic signed [gtp_pkg::HDG_W-1:0]  i_current_heading,
    input  logic [gtp_pkg::SQ_W-1:0]          i_arrive_sq,
    output logic                              o_vld,
    output gtp_pkg::t_cell                    o_cell
);
    import gtp_pkg::*;

    localparam int EXT_W = XY_W - D_W - CORDIC_SHIFT;

    // stage 0: offset
    logic                    r_v0;
    logic signed [D_W-1:0]   r0_dx;
    logic signed [D_W-1:0]   r0_dy;
    logic signed [HDG_W-1:0] r0_hd;

    // stage 1: squares
    logic                    r_v1;
    logic [SQ_W-1:0]         r1_sqx;
    logic [SQ_W-1:0]         r1_sqy;
    logic signed [D_W-1:0]   r1_dx;
    logic signed [D_W-1:0]   r1_dy;
    logic signed [HDG_W-1:0] r1_hd;

    // stage 2: chain entry
    logic                    r_v2;
    t_cell                   r_cell;
    t_cell                   n_cell;

    logic signed [2*D_W-1:0] w_sqx;
    logic signed [2*D_W-1:0] w_sqy;
    logic [DSQ_W-1:0]        w_dsq;
    logic signed [XY_W-1:0]  w_xe;
    logic signed [XY_W-1:0]  w_ye;

    assign w_sqx = r0_dx * r0_dx;
    assign w_sqy = r0_dy * r0_dy;
    assign w_dsq = {1'b0, r1_sqx} + {1'b0, r1_sqy};
    assign w_xe  = {{EXT_W{r1_dx[D_W-1]}}, r1_dx, {CORDIC_SHIFT{1'b0}}};
    assign w_ye  = {{EXT_W{r1_dy[D_W-1]}}, r1_dy, {CORDIC_SHIFT{1'b0}}};

    always_comb begin
        n_cell      = '0;
        n_cell.rad  = RAD_W'(w_dsq);
        n_cell.hd   = r1_hd;
        n_cell.zero = (r1_dx == '0) && (r1_dy == '0);
        n_cell.near = w_dsq < DSQ_W'(i_arrive_sq);
        // half-turn pre-rotation puts the vector in the right half plane
        if (r1_dx[D_W-1]) begin
            n_cell.x = -w_xe;
            n_cell.y = -w_ye;
            n_cell.z = r1_dy[D_W-1] ? -PI_Q20 : PI_Q20;
        end else begin
            n_cell.x = w_xe;
            n_cell.y = w_ye;
            n_cell.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_accept;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_dx  <= {i_target_x[POS_W-1], i_target_x} - {i_current_x[POS_W-1], i_current_x};
        r0_dy  <= {i_target_y[POS_W-1], i_target_y} - {i_current_y[POS_W-1], i_current_y};
        r0_hd  <= i_current_heading;
        r1_sqx <= w_sqx[SQ_W-1:0];
        r1_sqy <= w_sqy[SQ_W-1:0];
        r1_dx  <= r0_dx;
        r1_dy  <= r0_dy;
        r1_hd  <= r0_hd;
        r_cell <= n_cell;
    end

    assign o_vld  = r_v2;
    assign o_cell = r_cell;

endmodule

`default_nettype wire

// ===== sv/gtp_cell.sv =====
// ----------------------------------------------------------------------------
// gtp_cell: one cell of the bearing and distance chain
// Does a CORDIC vectoring micro-rotation if INDEX < ANGLE_STEPS and a digit
// of the integer square root if INDEX < SQRT_STEPS, then hands the state on.
// ----------------------------------------------------------------------------
`default_nettype none

module gtp_cell #(
    parameter int INDEX       = 0,
    parameter int ANGLE_STEPS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  gtp_pkg::t_cell i_d,
    output logic           o_vld,
    output gtp_pkg::t_cell o_q
);
    import gtp_pkg::*;

    localparam bit DO_ROT  = INDEX < ANGLE_STEPS;
    localparam bit DO_ROOT = INDEX < SQRT_STEPS;
    localparam logic [ATAN_IDX_W-1:0] ATAN_IDX = ATAN_IDX_W'(INDEX);

    logic                   r_vld;
    t_cell                  r_q;
    t_cell                  n_q;
    logic signed [XY_W-1:0] w_xs;
    logic signed [XY_W-1:0] w_ys;
    logic                   w_ypos;
    logic signed [Z_W-1:0]  w_atan;
    logic [REM_W-1:0]       w_rem_t;
    logic [REM_W-1:0]       w_trial;

    assign w_xs    = i_d.x >>> INDEX;
    assign w_ys    = i_d.y >>> INDEX;
    assign w_ypos  = !i_d.y[XY_W-1] && (i_d.y != '0);
    assign w_atan  = atan_q20(ATAN_IDX);
    assign w_rem_t = {i_d.rem[REM_W-3:0], i_d.rad[RAD_W-1 -: 2]};
    assign w_trial = {1'b0, i_d.root, 2'b01};

    always_comb begin
        n_q = i_d;
        if (DO_ROT) begin
            // rotate toward the x axis
            if (w_ypos) begin
                n_q.x = i_d.x + w_ys;
                n_q.y = i_d.y - w_xs;
                n_q.z = i_d.z + w_atan;
            end else begin
                n_q.x = i_d.x - w_ys;
                n_q.y = i_d.y + w_xs;
                n_q.z = i_d.z - w_atan;
            end
        end
        if (DO_ROOT) begin
            n_q.rad = {i_d.rad[RAD_W-3:0], 2'b00};
            if (w_rem_t >= w_trial) begin
                n_q.rem  = w_rem_t - w_trial;
                n_q.root = {i_d.root[ROOT_W-2:0], 1'b1};
            end else begin
                n_q.rem  = w_rem_t;
                n_q.root = {i_d.root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_vld = r_vld;
    assign o_q   = r_q;

`ifndef SYNTH
    // root remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> (o_q.rem <= REM_W'({o_q.root, 1'b0})))
        else $error("gtp_cell: root remainder out of bound");

    // after pre-rotation x only grows, so it stays non-negative
    a_x_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> !o_q.x[XY_W-1])
        else $error("gtp_cell: CORDIC x went negative");
`endif

endmodule

`default_nettype wire

// ===== sv/gtp_back.sv =====
// ----------------------------------------------------------------------------
// gtp_back: velocity scaling, clamping and outcome
// Rounds the bearing, forms the heading error, scales both velocities by
// their gains, clamps them to full scale and classifies the outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module gtp_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    input  gtp_pkg::t_cell                     i_d,
    input  logic [gtp_pkg::GAIN_W-1:0]         i_distance_gain,
    input  logic [gtp_pkg::GAIN_W-1:0]         i_heading_gain,
    input  logic [gtp_pkg::LIM_W-1:0]          i_heading_limit,
    output logic                               o_strobe,
    output logic [gtp_pkg::FWD_W-1:0]          o_forward_velocity,
    output logic signed [gtp_pkg::TURN_W-1:0]  o_turn_velocity,
    output logic [gtp_pkg::OUT_W-1:0]          o_outcome
);
    import gtp_pkg::*;

    localparam int FPROD_W = ROOT_W + GAIN_W;
    localparam int FSH_W   = FPROD_W + 1 - 4;
    localparam int TPROD_W = ERR_W + GAIN_W + 1;
    localparam int TSH_W   = TPROD_W - 6;
    localparam logic [FSH_W-1:0]        F_MAX = FSH_W'(FULL_SCALE);
    localparam logic signed [TSH_W-1:0] T_MAX = TSH_W'(FULL_SCALE);
    localparam logic signed [TSH_W-1:0] T_MIN = -T_MAX;

    // stage 1
    logic                      r_v1;
    logic signed [ERR_W-1:0]   r1_err;
    logic [FPROD_W-1:0]        r1_fprod;
    logic                      r1_near;
    // stage 2
    logic                      r_v2;
    logic signed [TPROD_W-1:0] r2_tprod;
    logic [FWD_W-1:0]          r2_fwd;
    logic [OUT_W-1:0]          r2_outcome;
    // output stage
    logic                      r_strobe;
    logic [FWD_W-1:0]          r_fwd;
    logic signed [TURN_W-1:0]  r_turn;
    logic [OUT_W-1:0]          r_outcome;

    logic signed [Z_W-1:0]     w_zr;
    logic signed [BEAR_W-1:0]  w_bear;
    logic [ERR_W-1:0]          w_aerr;
    logic [ERR_W-1:0]          w_lim;
    logic [FPROD_W:0]          w_fsum;
    logic [FSH_W-1:0]          w_fsh;
    logic signed [TPROD_W-1:0] w_tsum;
    logic signed [TSH_W-1:0]   w_tsh;
    logic [OUT_W-1:0]          n_outcome;

    // round half up to 1/4096 rad; zero offset has bearing zero
    assign w_zr   = i_d.z + Z_W'(128);
    assign w_bear = i_d.zero ? '0 : w_zr[Z_W-1:8];

    assign w_aerr = r1_err[ERR_W-1] ? ERR_W'(-r1_err) : ERR_W'(r1_err);
    assign w_lim  = ERR_W'(i_heading_limit);
    assign w_fsum = {1'b0, r1_fprod} + (FPROD_W+1)'(8);
    assign w_fsh  = w_fsum[FPROD_W:4];
    assign w_tsum = r2_tprod + TPROD_W'(32);
    assign w_tsh  = w_tsum[TPROD_W-1:6];

    always_comb begin
        priority if (r1_near && (w_aerr < w_lim)) begin
            n_outcome = OUT_ARRIVED;
        end else if (w_aerr > w_lim) begin
            n_outcome = OUT_TURN;
        end else begin
            n_outcome = OUT_CONTINUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v1     <= i_vld;
            r_v2     <= r_v1;
            r_strobe <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_err     <= {w_bear[BEAR_W-1], w_bear} - ERR_W'(i_d.hd);
        r1_fprod   <= FPROD_W'(i_d.root) * FPROD_W'(i_distance_gain);
        r1_near    <= i_d.near;
        r2_tprod   <= TPROD_W'(r1_err) * $signed(TPROD_W'({1'b0, i_heading_gain}));
        r2_fwd     <= (w_fsh > F_MAX) ? F_MAX[FWD_W-1:0] : w_fsh[FWD_W-1:0];
        r2_outcome <= n_outcome;
        // clamp turn to plus or minus full scale
        priority if (w_tsh > T_MAX) begin
            r_turn <= T_MAX[TURN_W-1:0];
        end else if (w_tsh < T_MIN) begin
            r_turn <= T_MIN[TURN_W-1:0];
        end else begin
            r_turn <= w_tsh[TURN_W-1:0];
        end
        r_fwd      <= r2_fwd;
        r_outcome  <= r2_outcome;
    end

    assign o_strobe           = r_strobe;
    assign o_forward_velocity = r_fwd;
    assign o_turn_velocity    = r_turn;
    assign o_outcome          = r_outcome;

endmodule

`default_nettype wire

// ===== sv/go_to_pose_velocity_controller.sv =====
// Pipeline: front stages (offset, squares, chain entry), CHAIN_LEN cells,
//   CHAIN_LEN = max(ANGLE_STEPS, 17), then the back stages up to the strobe.
// Throughput: one pose per cycle; the cell chain takes a new transaction each
//   cycle, at most one CORDIC rotation and one root digit per cell.
// Reset: synchronous, clears valid bits and loads the register defaults; busy
//   is high and configuration is held off during reset.
// ----------------------------------------------------------------------------
// go_to_pose_velocity_controller: proportional go-to-goal velocity controller
// Computes distance and bearing to the target through a chain of cells and
// turns them into clamped forward and turn velocities and an outcome code.
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_pose_velocity_controller #(
    parameter int ANGLE_STEPS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [gtp_pkg::POS_W-1:0]      i_target_x,
    input  logic signed [gtp_pkg::POS_W-1:0]      i_target_y,
    input  logic signed [gtp_pkg::POS_W-1:0]      i_current_x,
    input  logic signed [gtp_pkg::POS_W-1:0]      i_current_y,
    input  logic signed [gtp_pkg::HDG_W-1:0]      i_current_heading,
    output logic                                  o_strobe,
    output logic [gtp_pkg::FWD_W-1:0]             o_forward_velocity,
    output logic signed [gtp_pkg::TURN_W-1:0]     o_turn_velocity,
    output logic [gtp_pkg::OUT_W-1:0]             o_outcome,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [gtp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [gtp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import gtp_pkg::*;

    localparam int CHAIN_LEN = (ANGLE_STEPS > SQRT_STEPS) ? ANGLE_STEPS : SQRT_STEPS;

    logic               r_run;
    logic [GAIN_W-1:0]  r_distance_gain;
    logic [GAIN_W-1:0]  r_heading_gain;
    logic [DIST_W-1:0]  r_arrive_distance;
    logic [LIM_W-1:0]   r_heading_limit;
    logic [SQ_W-1:0]    r_arrive_sq;
    logic               w_accept;
    logic               w_cfg_wr;

    logic               w_vld  [CHAIN_LEN+1];
    t_cell              w_cell [CHAIN_LEN+1];

    assign w_accept    = start && !busy;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign busy        = !r_run;
    assign o_cfg_ready = r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run             <= 1'b0;
            r_distance_gain   <= GAIN_W'(768);
            r_heading_gain    <= GAIN_W'(256);
            r_arrive_distance <= DIST_W'(51);
            r_heading_limit   <= LIM_W'(1638);
        end else begin
            r_run <= 1'b1;
            if (w_cfg_wr) begin
                unique case (i_cfg_index)
                    REG_DIST_GAIN: r_distance_gain   <= i_cfg_data[GAIN_W-1:0];
                    REG_HDG_GAIN:  r_heading_gain    <= i_cfg_data[GAIN_W-1:0];
                    REG_ARRIVE:    r_arrive_distance <= i_cfg_data[DIST_W-1:0];
                    REG_HDG_LIMIT: r_heading_limit   <= i_cfg_data[LIM_W-1:0];
                endcase
            end
        end
    end

    // threshold squared, settles in the cycle after a write
    always_ff @(posedge i_clk) begin
        r_arrive_sq <= SQ_W'(r_arrive_distance) * SQ_W'(r_arrive_distance);
    end

    gtp_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (w_accept),
        .i_target_x        (i_target_x),
        .i_target_y        (i_target_y),
        .i_current_x       (i_current_x),
        .i_current_y       (i_current_y),
        .i_current_heading (i_current_heading),
        .i_arrive_sq       (r_arrive_sq),
        .o_vld             (w_vld[0]),
        .o_cell            (w_cell[0])
    );

    for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_chain
        gtp_cell #(
            .INDEX       (g),
            .ANGLE_STEPS (ANGLE_STEPS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .i_d     (w_cell[g]),
            .o_vld   (w_vld[g+1]),
            .o_q     (w_cell[g+1])
        );
    end

    gtp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_vld              (w_vld[CHAIN_LEN]),
        .i_d                (w_cell[CHAIN_LEN]),
        .i_distance_gain    (r_distance_gain),
        .i_heading_gain     (r_heading_gain),
        .i_heading_limit    (r_heading_limit),
        .o_strobe           (o_strobe),
        .o_forward_velocity (o_forward_velocity),
        .o_turn_velocity    (o_turn_velocity),
        .o_outcome          (o_outcome)
    );

`ifndef SYNTH
    a_fwd_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_forward_velocity <= FWD_W'(FULL_SCALE)))
        else $error("forward velocity above full scale");

    a_turn_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_turn_velocity <= $signed(TURN_W'(FULL_SCALE)))
                   && (o_turn_velocity >= -$signed(TURN_W'(FULL_SCALE)))))
        else $error("turn velocity outside full scale");

    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_outcome != OUT_RSVD))
        else $error("reserved outcome code");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the go-to-pose velocity controller
// Sends poses through the start/busy port and checks every strobed result
// against table values or a bit-exact predictor of distance, CORDIC bearing,
// clamped velocities and outcome. Starts with a directed table, then random
// poses under several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
    import gtp_pkg::*;

    localparam int ANGLE_STEPS = 16;
    localparam int CHAIN_LEN   = (ANGLE_STEPS > 17) ? ANGLE_STEPS : 17;
    localparam int LATENCY     = CHAIN_LEN + 5;
    localparam int PHASE_POSES = 180;
    localparam int CYCLE_LIMIT = 40000;
    localparam longint PI_Q20_RAD = 64'sd3294199;

    typedef struct {
        logic signed [POS_W-1:0] tx;
        logic signed [POS_W-1:0] ty;
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic signed [HDG_W-1:0] hd;
    } t_pose;

    typedef struct {
        logic [FWD_W-1:0]         fwd;
        logic signed [TURN_W-1:0] turn;
        logic [OUT_W-1:0]         outcome;
    } t_steer;

    typedef struct {
        t_pose  p;
        bit     typed;
        t_steer want;
    } t_plan_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic signed [POS_W-1:0]  i_target_x;
    logic signed [POS_W-1:0]  i_target_y;
    logic signed [POS_W-1:0]  i_current_x;
    logic signed [POS_W-1:0]  i_current_y;
    logic signed [HDG_W-1:0]  i_current_heading;
    logic                     o_strobe;
    logic [FWD_W-1:0]         o_forward_velocity;
    logic signed [TURN_W-1:0] o_turn_velocity;
    logic [OUT_W-1:0]         o_outcome;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;

    // Register shadow
    logic [GAIN_W-1:0] dist_gain;
    logic [GAIN_W-1:0] hdg_gain;
    logic [DIST_W-1:0] arrive_d;
    logic [LIM_W-1:0]  hdg_lim;

    bit        plan_typed;
    t_steer    plan_want;
    t_steer    steer_due[$];
    t_plan_row pose_plan[$];

    int n_cycles = 0;
    int n_poses = 0;
    int n_bad = 0;
    int n_settings = 1;
    int n_arrived = 0;
    int n_turn = 0;
    int n_cont = 0;

    go_to_pose_velocity_controller #(
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_target_x         (i_target_x),
        .i_target_y         (i_target_y),
        .i_current_x        (i_current_x),
        .i_current_y        (i_current_y),
        .i_current_heading  (i_current_heading),
        .o_strobe           (o_strobe),
        .o_forward_velocity (o_forward_velocity),
        .o_turn_velocity    (o_turn_velocity),
        .o_outcome          (o_outcome),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // atan(2^-i) in 2^-20 rad; a plain power of two from step 7 to 20, zero beyond
    function automatic longint atan_step(input int i);
        case (i)
            0: return 823550;
            1: return 486170;
            2: return 256879;
            3: return 130396;
            4: return 65451;
            5: return 32757;
            6: return 16383;
            default: return (i <= 20) ? (longint'(1) << (20 - i)) : 0;
        endcase
    endfunction

    // atan2(dy, dx) in 1/4096 rad, vectoring CORDIC on offsets scaled by 2^16
    function automatic longint aim_bearing(input longint dx, input longint dy);
        longint x, y, z, xs, ys;
        if (dx == 0 && dy == 0)
            return 0;
        x = dx * 65536;
        y = dy * 65536;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q20_RAD : -PI_Q20_RAD;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ANGLE_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(i);
            end
        end
        return (z + 128) >>> 8;
    endfunction

    function automatic longint root_floor(input longint n);
        longint r, c;
        r = 0;
        for (int k = 17; k >= 0; k--) begin
            c = r | (longint'(1) << k);
            if (c * c <= n)
                r = c;
        end
        return r;
    endfunction

    function automatic t_steer steer_predict(input t_pose p);
        longint dx, dy, dsq, span, err, aerr, turn, fwd;
        t_steer s;
        dx   = longint'(p.tx) - longint'(p.cx);
        dy   = longint'(p.ty) - longint'(p.cy);
        dsq  = dx * dx + dy * dy;
        span = root_floor(dsq);
        err  = aim_bearing(dx, dy) - longint'(p.hd);
        aerr = (err < 0) ? -err : err;
        turn = (err * longint'(hdg_gain) + 32) >>> 6;
        fwd  = (span * longint'(dist_gain) + 8) >>> 4;
        if (turn > FULL_SCALE)
            turn = FULL_SCALE;
        else if (turn < -FULL_SCALE)
            turn = -FULL_SCALE;
        if (fwd > FULL_SCALE)
            fwd = FULL_SCALE;
        s.fwd  = FWD_W'(fwd);
        s.turn = TURN_W'(turn);
        if (dsq < longint'(arrive_d) * longint'(arrive_d) && aerr < longint'(hdg_lim))
            s.outcome = OUT_ARRIVED;
        else if (aerr > longint'(hdg_lim))
            s.outcome = OUT_TURN;
        else
            s.outcome = OUT_CONTINUE;
        return s;
    endfunction

    task automatic add_row(input int tx, input int ty, input int cx, input int cy,
                           input int hd, input bit typed, input int fwd, input int turn,
                           input logic [OUT_W-1:0] oc);
        t_plan_row r;
        r.p.tx = POS_W'(tx);
        r.p.ty = POS_W'(ty);
        r.p.cx = POS_W'(cx);
        r.p.cy = POS_W'(cy);
        r.p.hd = HDG_W'(hd);
        r.typed = typed;
        r.want.fwd = FWD_W'(fwd);
        r.want.turn = TURN_W'(turn);
        r.want.outcome = oc;
        pose_plan.push_back(r);
    endtask

    task automatic send_pose(input t_pose p, input bit typed, input t_steer want,
                             input bit steady);
        int gap;
        if (!steady && $urandom_range(0, 99) < 14) begin
            gap = $urandom_range(1, 3);
            repeat (gap) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        start             <= 1'b1;
        i_target_x        <= p.tx;
        i_target_y        <= p.ty;
        i_current_x       <= p.cx;
        i_current_y       <= p.cy;
        i_current_heading <= p.hd;
        plan_typed        <= typed;
        plan_want         <= want;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        if ($urandom_range(0, 99) < 14) begin
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_setting(input int dg, input int hg, input int ad, input int hl);
        // drain the pipe before touching any register
        @(negedge i_clk);
        start <= 1'b0;
        while (steer_due.size() != 0)
            @(posedge i_clk);
        write_reg(REG_DIST_GAIN, CFG_DATA_W'(dg));
        write_reg(REG_HDG_GAIN,  CFG_DATA_W'(hg));
        write_reg(REG_ARRIVE,    CFG_DATA_W'(ad));
        write_reg(REG_HDG_LIMIT, CFG_DATA_W'(hl));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic run_phase(input int n, input bit steady);
        t_pose  p;
        t_steer none;
        int     mode, reach, dx, dy, e;
        longint bear;
        none.fwd     = '0;
        none.turn    = '0;
        none.outcome = OUT_CONTINUE;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(0, 99);
            p.tx = POS_W'($urandom);
            p.ty = POS_W'($urandom);
            p.cx = POS_W'($urandom);
            p.cy = POS_W'($urandom);
            p.hd = HDG_W'($urandom);
            if (mode >= 35) begin
                // near the arrival radius, then near the heading limit, then zero offset
                if (mode < 60)
                    reach = (2 * arrive_d + 4 < 16000) ? 2 * arrive_d + 4 : 16000;
                else if (mode < 85)
                    reach = 16000;
                else
                    reach = 0;
                dx = int'($urandom_range(0, 2 * reach)) - reach;
                dy = int'($urandom_range(0, 2 * reach)) - reach;
                p.cx = POS_W'(int'($urandom_range(0, 32767)) - 16384);
                p.cy = POS_W'(int'($urandom_range(0, 32767)) - 16384);
                p.tx = POS_W'(int'(p.cx) + dx);
                p.ty = POS_W'(int'(p.cy) + dy);
                if (mode < 85) begin
                    bear = aim_bearing(dx, dy);
                    if (mode < 60)
                        e = int'($urandom_range(0, 2 * hdg_lim + 4)) - int'(hdg_lim) - 2;
                    else
                        e = (int'($urandom_range(0, 1)) * 2 - 1)
                            * (int'(hdg_lim) + int'($urandom_range(0, 2)) - 1);
                    p.hd = HDG_W'(bear - e);
                end
            end
            send_pose(p, 1'b0, none, steady);
        end
    endtask

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time, steer_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin : watch
        t_pose  p;
        t_steer w;
        if (!i_rst_n) begin
            dist_gain <= 12'd768;
            hdg_gain  <= 12'd256;
            arrive_d  <= 16'd51;
            hdg_lim   <= 15'd1638;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_DIST_GAIN: dist_gain <= i_cfg_data[GAIN_W-1:0];
                    REG_HDG_GAIN:  hdg_gain  <= i_cfg_data[GAIN_W-1:0];
                    REG_ARRIVE:    arrive_d  <= i_cfg_data[DIST_W-1:0];
                    REG_HDG_LIMIT: hdg_lim   <= i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                p.tx = i_target_x;
                p.ty = i_target_y;
                p.cx = i_current_x;
                p.cy = i_current_y;
                p.hd = i_current_heading;
                if (plan_typed)
                    steer_due.push_back(plan_want);
                else
                    steer_due.push_back(steer_predict(p));
                n_poses++;
            end
            if (o_strobe) begin
                if (steer_due.size() == 0) begin
                    n_bad++;
                    $display("%0t: unexpected result fwd %0d turn %0d outcome %0d", $time,
                             o_forward_velocity, o_turn_velocity, o_outcome);
                end else begin
                    w = steer_due.pop_front();
                    if (o_forward_velocity !== w.fwd) begin
                        n_bad++;
                        $display("%0t: forward_velocity expected %0d actual %0d", $time,
                                 w.fwd, o_forward_velocity);
                    end
                    if (o_turn_velocity !== w.turn) begin
                        n_bad++;
                        $display("%0t: turn_velocity expected %0d actual %0d", $time,
                                 w.turn, o_turn_velocity);
                    end
                    if (o_outcome !== w.outcome) begin
                        n_bad++;
                        $display("%0t: outcome expected %0d actual %0d", $time,
                                 w.outcome, o_outcome);
                    end
                    case (w.outcome)
                        OUT_ARRIVED: n_arrived++;
                        OUT_TURN:    n_turn++;
                        default:     n_cont++;
                    endcase
                end
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_target_x        = '0;
        i_target_y        = '0;
        i_current_x       = '0;
        i_current_y       = '0;
        i_current_heading = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = REG_DIST_GAIN;
        i_cfg_data        = '0;
        plan_typed        = 1'b0;
        plan_want.fwd     = '0;
        plan_want.turn    = '0;
        plan_want.outcome = OUT_CONTINUE;

        // Directed poses at the reset settings.
        // zero offset: bearing is 0, so the heading alone sets the error
        add_row(0, 0, 0, 0, 0,            1, 0, 0,      OUT_ARRIVED);
        add_row(32767, -32768, 32767, -32768, 0, 1, 0, 0, OUT_ARRIVED);
        add_row(-32768, 32767, -32768, 32767, 0, 1, 0, 0, OUT_ARRIVED);
        add_row(0, 0, 0, 0, 12868,        1, 0, -16384, OUT_TURN);
        add_row(0, 0, 0, 0, -12868,       1, 0, 16384,  OUT_TURN);
        // heading error right at, under and over the limit
        add_row(0, 0, 0, 0, 1638,         1, 0, -6552,  OUT_CONTINUE);
        add_row(0, 0, 0, 0, 1637,         1, 0, -6548,  OUT_ARRIVED);
        add_row(0, 0, 0, 0, -1639,        1, 0, 6556,   OUT_TURN);
        // heading patterns past plus or minus pi
        add_row(0, 0, 0, 0, -16384,       1, 0, 16384,  OUT_TURN);
        add_row(0, 0, 0, 0, 16383,        1, 0, -16384, OUT_TURN);
        // largest offsets along axes and diagonals
        add_row(32767, 0, -32768, 0, 0,          0, 0, 0, OUT_CONTINUE);
        add_row(-32768, 0, 32767, 0, 12868,      0, 0, 0, OUT_CONTINUE);
        add_row(0, 32767, 0, -32768, 6434,       0, 0, 0, OUT_CONTINUE);
        add_row(0, -32768, 0, 32767, -6434,      0, 0, 0, OUT_CONTINUE);
        add_row(32767, 32767, -32768, -32768, 3217,   0, 0, 0, OUT_CONTINUE);
        add_row(-32768, -32768, 32767, 32767, -9651,  0, 0, 0, OUT_CONTINUE);
        add_row(-32768, 32767, 32767, -32768, 9651,   0, 0, 0, OUT_CONTINUE);
        add_row(32767, -32768, -32768, 32767, -3217,  0, 0, 0, OUT_CONTINUE);
        // negative x offset on the axis and just below it
        add_row(-1, 0, 0, 0, 12868,       0, 0, 0, OUT_CONTINUE);
        add_row(-1, -1, 0, 0, -12868,     0, 0, 0, OUT_CONTINUE);
        // around the arrival radius
        add_row(50, 0, 0, 0, 0,           0, 0, 0, OUT_CONTINUE);
        add_row(51, 0, 0, 0, 0,           0, 0, 0, OUT_CONTINUE);
        add_row(136, 136, 100, 100, 3217, 0, 0, 0, OUT_CONTINUE);
        add_row(0, 1000, 0, 0, 6434,      0, 0, 0, OUT_CONTINUE);
        add_row(1, 0, 0, 0, 0,            0, 0, 0, OUT_CONTINUE);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (pose_plan[j])
            send_pose(pose_plan[j].p, pose_plan[j].typed, pose_plan[j].want, 1'b0);
        run_phase(PHASE_POSES, 1'b0);

        apply_setting(1, 4095, 0, 0);
        run_phase(PHASE_POSES, 1'b0);
        // no gaps under the largest settings
        apply_setting(4095, 4095, 65535, 25736);
        run_phase(PHASE_POSES, 1'b1);
        apply_setting(0, 0, 0, 0);
        run_phase(PHASE_POSES, 1'b0);
        apply_setting($urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 2000), $urandom_range(0, 4000));
        run_phase(PHASE_POSES, 1'b0);
        apply_setting(768, 256, 51, 1638);
        run_phase(PHASE_POSES, 1'b0);

        @(negedge i_clk);
        start <= 1'b0;
        while (steer_due.size() != 0)
            @(posedge i_clk);
        // catch any stray strobe
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("Checked %0d poses under %0d register settings", n_poses, n_settings);
        $display("Outcomes: %0d arrived, %0d turn, %0d continue", n_arrived, n_turn, n_cont);
        if (n_bad == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== go_to_pose_velocity_controller.f =====
sv/gtp_pkg.sv
sv/gtp_front.sv
sv/gtp_cell.sv
sv/gtp_back.sv
sv/go_to_pose_velocity_controller.sv
verif/tb_top.sv
